FILE: src/wildcard_key_value_table_unit_macros.svh
// Assertion macros used by the checker of the wildcard key-value table.
// Depends on nothing; take it in with an include of the bare file name.
`ifndef WILDCARD_KEY_VALUE_TABLE_UNIT_MACROS_SVH
`define WILDCARD_KEY_VALUE_TABLE_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WKV_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wkv check failed");

// Consequent must hold in the cycle after the antecedent.
`define WKV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wkv check failed");

`endif

FILE: src/wkv_pkg.sv
// Types and codes of the wildcard key-value table.
// Depends on nothing; every other file of the block but the macros header imports it.
`timescale 1ns / 1ps
`default_nettype none

package wkv_pkg;

    localparam int unsigned KEY_W   = 32;
    localparam int unsigned VALUE_W = 64;

    // Request opcodes; code 3 is ignored by the block
    localparam logic [1:0] OP_LOOKUP   = 2'd0;
    localparam logic [1:0] OP_INSERT   = 2'd1;
    localparam logic [1:0] OP_WILDCARD = 2'd2;

    // Response status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_PRESENT   = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_EMPTY = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_FINISH
    } state_t;

    // Search word that walks the row of cells
    typedef struct packed {
        logic               active;
        logic               match_any;
        logic [KEY_W-1:0]   key;
        logic               hit;
        logic [VALUE_W-1:0] value;
    } token_t;

    // Data written into one cell
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } wr_data_t;

endpackage

`default_nettype wire

FILE: src/wkv_req_if.sv
// Request channel of the wildcard key-value table.
// Depends on wkv_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface wkv_req_if;
    import wkv_pkg::*;

    logic               valid;
    logic               ready;
    logic [1:0]         opcode;
    logic [KEY_W-1:0]   lookup_key;
    logic [VALUE_W-1:0] entry_value;

    modport source (output valid, output opcode, output lookup_key, output entry_value,
                    input ready);
    modport sink   (input valid, input opcode, input lookup_key, input entry_value,
                    output ready);
endinterface

`default_nettype wire

FILE: src/wkv_rsp_if.sv
// Response channel of the wildcard key-value table.
// Depends on wkv_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface wkv_rsp_if;
    import wkv_pkg::*;

    logic               valid;
    logic               ready;
    logic               found;
    logic [VALUE_W-1:0] read_value;
    logic [1:0]         status;
    logic               modified;

    modport source (output valid, output found, output read_value, output status,
                    output modified, input ready);
    modport sink   (input valid, input found, input read_value, input status,
                    input modified, output ready);
endinterface

`default_nettype wire

FILE: src/wkv_cell.sv
// One table entry: holds a key and value, compares the passing search word.
// Depends on wkv_pkg for the token and write types.
`timescale 1ns / 1ps
`default_nettype none

module wkv_cell
    import wkv_pkg::*;
#(
    parameter int unsigned CNT_W = 5,
    parameter int unsigned IDX   = 0
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [CNT_W-1:0] count,
    input  wire token_t           tok_in,
    output token_t                tok_out,
    input  wire logic             wr_en,
    input  wire wr_data_t         wr_data
);

    logic [KEY_W-1:0]   key_reg;
    logic [VALUE_W-1:0] value_reg;
    token_t             tok_reg;
    token_t             tok_next;
    logic               cell_valid;
    logic               match;

    assign cell_valid = (count > CNT_W'(IDX));
    assign match      = tok_in.active && cell_valid
                        && (tok_in.match_any || (key_reg == tok_in.key));

    // Take the value on the first match only
    always_comb
    begin
        tok_next = tok_in;
        if (match && !tok_in.hit)
        begin
            tok_next.hit   = 1'b1;
            tok_next.value = value_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_reg   <= wr_data.key;
            value_reg <= wr_data.value;
        end
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire

FILE: src/wildcard_key_value_table_unit.sv
// Wildcard key-value table. Holds up to TABLE_DEPTH entries of a 32-bit key
// and a 64-bit value in a row of cells. A lookup or an insert sends a search
// word down the row, one cell per clock, from the launch register through
// every cell, and the outcome passes the finish state to the output register;
// a wildcard set, an insert while in wildcard mode and the unused opcode skip
// the walk and go straight to the finish state. One request is in work at
// a time: the next request word is taken as soon as the previous one has
// committed its table update, even while its response word still waits in
// the output register. A lookup answers found with the stored value, or with
// the wildcard value once wildcard mode is set; a miss gives found 0 and
// value 0. Refused requests leave the table untouched and report a status:
// key already present or wildcard mode on insert, table full on insert, or
// table not empty on wildcard set. modified goes high with the first
// successful insert or wildcard set and stays high until reset. Entries are
// filled in order from cell 0, so no entry is read before it is written.
`timescale 1ns / 1ps
`default_nettype none

module wildcard_key_value_table_unit
    import wkv_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 16
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    wkv_req_if.sink   req,
    wkv_rsp_if.source rsp
);

    localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // Control state
    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               wildcard_reg, wildcard_next;
    logic               modified_reg, modified_next;
    token_t             launch_reg, launch_next;

    // Request held while in work, search outcome
    logic [1:0]         op_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [VALUE_W-1:0] val_reg;
    logic               hit_reg;
    logic [VALUE_W-1:0] hitval_reg;

    // Output register
    logic               out_valid_reg, out_valid_next;
    logic               found_reg, found_next;
    logic [VALUE_W-1:0] rvalue_reg, rvalue_next;
    logic [1:0]         status_reg, status_next;
    logic               mod_out_reg;

    logic               accept;
    logic               commit;
    logic               do_write;
    logic               search_done;
    logic               needs_search;
    wr_data_t           wr_data;
    logic [TABLE_DEPTH-1:0] wr_en;
    token_t             chain [TABLE_DEPTH+1];

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;

    // Lookups always walk the row; inserts walk it unless wildcard mode refuses them
    assign needs_search = (req.opcode == OP_LOOKUP)
                          || ((req.opcode == OP_INSERT) && !wildcard_reg);

    assign chain[0]    = launch_reg;
    assign search_done = chain[TABLE_DEPTH].active;

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++)
        begin : g_cell
            assign wr_en[gi] = do_write && (count_reg[IDX_W-1:0] == IDX_W'(gi));

            wkv_cell #(
                .CNT_W (CNT_W),
                .IDX   (gi)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .count   (count_reg),
                .tok_in  (chain[gi]),
                .tok_out (chain[gi+1]),
                .wr_en   (wr_en[gi]),
                .wr_data (wr_data)
            );
        end
    endgenerate

    assign wr_data.key   = key_reg;
    assign wr_data.value = val_reg;

    // Launch a search word for one cycle after acceptance
    always_comb
    begin
        launch_next           = '0;
        launch_next.active    = accept && needs_search;
        launch_next.match_any = wildcard_reg;
        launch_next.key       = req.lookup_key;
    end

    // Next state, table update and response word
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        wildcard_next  = wildcard_reg;
        modified_next  = modified_reg;
        commit         = 1'b0;
        do_write       = 1'b0;
        found_next     = 1'b0;
        rvalue_next    = '0;
        status_next    = ST_OK;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = needs_search ? S_SEARCH : S_FINISH;
                end
            end
            S_SEARCH:
            begin
                if (search_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || rsp.ready)
                begin
                    commit     = 1'b1;
                    state_next = S_IDLE;
                    unique case (op_reg)
                        OP_LOOKUP:
                        begin
                            found_next  = hit_reg;
                            rvalue_next = hitval_reg;
                        end
                        OP_INSERT:
                        begin
                            if (wildcard_reg || hit_reg)
                            begin
                                status_next = ST_PRESENT;
                            end
                            else if (count_reg == CNT_W'(TABLE_DEPTH))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                do_write      = 1'b1;
                                count_next    = count_reg + CNT_W'(1);
                                modified_next = 1'b1;
                            end
                        end
                        OP_WILDCARD:
                        begin
                            if ((count_reg != '0) || wildcard_reg)
                            begin
                                status_next = ST_NOT_EMPTY;
                            end
                            else
                            begin
                                // Table empty: cell 0 takes the wildcard value
                                do_write      = 1'b1;
                                wildcard_next = 1'b1;
                                count_next    = CNT_W'(1);
                                modified_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            // Unused opcode: no change, empty response
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = commit || (out_valid_reg && !rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            wildcard_reg  <= 1'b0;
            modified_reg  <= 1'b0;
            launch_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            wildcard_reg  <= wildcard_next;
            modified_reg  <= modified_next;
            launch_reg    <= launch_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= req.opcode;
            key_reg    <= req.lookup_key;
            val_reg    <= req.entry_value;
            hit_reg    <= 1'b0;
            hitval_reg <= '0;
        end
        else if ((state_reg == S_SEARCH) && search_done)
        begin
            hit_reg    <= chain[TABLE_DEPTH].hit;
            hitval_reg <= chain[TABLE_DEPTH].value;
        end

        if (commit)
        begin
            found_reg   <= found_next;
            rvalue_reg  <= rvalue_next;
            status_reg  <= status_next;
            mod_out_reg <= modified_next;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.found      = found_reg;
    assign rsp.read_value = rvalue_reg;
    assign rsp.status     = status_reg;
    assign rsp.modified   = mod_out_reg;

endmodule

`default_nettype wire

FILE: src/wkv_checker.sv
// Port-level checks of the wildcard key-value table, bound to its top level.
// Depends on wkv_pkg and the assertion macros header.
`timescale 1ns / 1ps
`default_nettype none

`include "wildcard_key_value_table_unit_macros.svh"

module wkv_checker
    import wkv_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               req_valid,
    input wire logic               req_ready,
    input wire logic               rsp_valid,
    input wire logic               rsp_ready,
    input wire logic               rsp_found,
    input wire logic [VALUE_W-1:0] rsp_read_value,
    input wire logic [1:0]         rsp_status,
    input wire logic               rsp_modified
);

    logic seen_mod_reg;

    // Remember a delivered modified flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_mod_reg <= 1'b0;
        end
        else if (rsp_valid && rsp_ready && rsp_modified)
        begin
            seen_mod_reg <= 1'b1;
        end
    end

    `WKV_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_read_value) && $stable(rsp_status))
    `WKV_ASSERT_NEXT(a_one_in_work, clk, rst_n, req_valid && req_ready, !req_ready)
    `WKV_ASSERT_NOW(a_found_ok, clk, rst_n, rsp_valid && rsp_found, rsp_status == ST_OK)
    `WKV_ASSERT_NOW(a_modified_sticky, clk, rst_n, rsp_valid && seen_mod_reg, rsp_modified)

endmodule

bind wildcard_key_value_table_unit wkv_checker u_wkv_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_found      (rsp.found),
    .rsp_read_value (rsp.read_value),
    .rsp_status     (rsp.status),
    .rsp_modified   (rsp.modified)
);

`default_nettype wire
